// File: rtl/field_weakening_current_limits_defines.svh
// assertion macros for the field weakening limit block
`ifndef FIELD_WEAKENING_CURRENT_LIMITS_DEFINES_SVH
`define FIELD_WEAKENING_CURRENT_LIMITS_DEFINES_SVH

`ifndef SYNTHESIS

`define FWCL_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fwcl implication check failed");

`define FWCL_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fwcl next-cycle check failed");

`else

`define FWCL_IMPLIES(lbl, ante, cons)

`define FWCL_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/fwcl_pkg.sv
// shared types and constants for the field weakening limit block
`default_nettype none

package fwcl_pkg;

  // 1/sqrt(2) as an unsigned Q0.32 fraction
  localparam logic [31:0] INV_SQRT2_Q32 = 32'd3037000500;

  // 50*pi as an unsigned Q32.32 value
  localparam logic [63:0] FIFTY_PI_Q32 = 64'd674651885229;

  typedef struct packed {
    logic advance;
    logic valid;
  } pipe_ctl_t;

endpackage

`default_nettype wire

// File: rtl/fwcl_mulsat.sv
// registered multiply, fraction shift and saturation to a positive magnitude
`default_nettype none

module fwcl_mulsat #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16,
  parameter int TAG_BITS  = 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire fwcl_pkg::pipe_ctl_t  ctl,
  input  wire logic [WORD_BITS-2:0] op_a,
  input  wire logic [WORD_BITS-2:0] op_b,
  input  wire logic [TAG_BITS-1:0]  tag,
  output logic                      out_valid,
  output logic [WORD_BITS-2:0]      prod,
  output logic [TAG_BITS-1:0]       tag_out
);

  localparam int PW = 2 * WORD_BITS - 2;

  logic [PW-1:0] prod_r;
  logic [PW-1:0] shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.advance) begin
      out_valid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      prod_r  <= PW'(op_a) * PW'(op_b);
      tag_out <= tag;
    end
  end

  assign shifted = prod_r >> FRAC_BITS;
  assign prod = (|shifted[PW-1:WORD_BITS-1]) ? '1 : shifted[WORD_BITS-2:0];

endmodule

`default_nettype wire

// File: rtl/fwcl_div.sv
// pipelined restoring divider, one quotient bit per stage, saturating quotient
`default_nettype none

module fwcl_div #(
  parameter int WORD_BITS = 32,
  parameter int TAG_BITS  = 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire fwcl_pkg::pipe_ctl_t    ctl,
  input  wire logic [2*WORD_BITS-3:0] num,
  input  wire logic [WORD_BITS-1:0]   den,
  input  wire logic [TAG_BITS-1:0]    tag,
  output logic                        out_valid,
  output logic [WORD_BITS-2:0]        quo,
  output logic [TAG_BITS-1:0]         tag_out
);

  localparam int STEPS = WORD_BITS - 1;
  localparam int NB    = 2 * WORD_BITS - 2;

  logic                  v_s   [0:STEPS];
  logic                  sat_s [0:STEPS];
  logic [WORD_BITS-1:0]  rem_s [0:STEPS];
  logic [WORD_BITS-1:0]  den_s [0:STEPS];
  logic [WORD_BITS-2:0]  lo_s  [0:STEPS];
  logic [WORD_BITS-2:0]  q_s   [0:STEPS];
  logic [TAG_BITS-1:0]   tag_s [0:STEPS];

  logic [WORD_BITS-1:0] hi;

  // quotient overflows the magnitude range exactly when the upper half reaches den
  assign hi = {1'b0, num[NB-1:WORD_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else if (ctl.advance) begin
      v_s[0] <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      rem_s[0] <= hi;
      den_s[0] <= den;
      lo_s[0]  <= num[WORD_BITS-2:0];
      q_s[0]   <= '0;
      sat_s[0] <= (hi >= den);
      tag_s[0] <= tag;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [WORD_BITS:0] trial;
    logic [WORD_BITS:0] diff;
    logic               ge;

    assign trial = {rem_s[k], lo_s[k][WORD_BITS-2]};
    assign diff  = trial - {1'b0, den_s[k]};
    assign ge    = (trial >= {1'b0, den_s[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k+1] <= 1'b0;
      end else if (ctl.advance) begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.advance) begin
        rem_s[k+1] <= ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
        den_s[k+1] <= den_s[k];
        lo_s[k+1]  <= lo_s[k] << 1;
        q_s[k+1]   <= {q_s[k][WORD_BITS-3:0], ge};
        sat_s[k+1] <= sat_s[k];
        tag_s[k+1] <= tag_s[k];
      end
    end
  end

  assign out_valid = v_s[STEPS];
  assign quo       = sat_s[STEPS] ? '1 : q_s[STEPS];
  assign tag_out   = tag_s[STEPS];

endmodule

`default_nettype wire

// File: rtl/field_weakening_current_limits.sv
// top level of the field weakening current and torque limit pipeline
`default_nettype none

`include "field_weakening_current_limits_defines.svh"

// Takes one signed velocity sample per clock and returns the d current, the q
// current limits and the torque limits, all fixed point with FRAC_BITS fraction
// bits. The path runs through three ranks of pipelined restoring dividers of
// WORD_BITS stages each (speed ratio, torque scale, and a pair for the torque
// limits) plus six multiply and register stages. One item is accepted every
// clock; the whole pipeline holds while a finished result is stalled at the
// output register. Configuration is read at stage 0, by the torque boost
// multiply and at stage 4, so write it only while the pipeline is empty.
module field_weakening_current_limits #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [2:0]                  cfg_index,
  input  wire logic [WORD_BITS-2:0]        cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic signed [WORD_BITS-1:0] velocity,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [WORD_BITS-1:0]      d_current,
  output logic signed [WORD_BITS-1:0]      q_current_max,
  output logic signed [WORD_BITS-1:0]      q_current_min,
  output logic signed [WORD_BITS-1:0]      torque_max,
  output logic signed [WORD_BITS-1:0]      torque_min
);

  localparam int W  = WORD_BITS;
  localparam int M  = WORD_BITS - 1;
  localparam int PW = 2 * WORD_BITS - 2;
  localparam int IW = WORD_BITS + 32;

  localparam int FLOOR_INT = ((1 << FRAC_BITS) + 50) / 100;
  localparam logic [W-1:0] FLOOR_01 = W'(FLOOR_INT);

  localparam logic [63:0] RV_WIDE =
    (fwcl_pkg::FIFTY_PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  localparam logic [M-1:0] RV_RESET = M'(RV_WIDE);
  localparam logic [M-1:0] RC_RESET = M'(64'd15 << FRAC_BITS);
  localparam logic [M-1:0] RT_RESET = M'(64'd23 << FRAC_BITS);
  localparam logic [M-1:0] VB_RESET = M'(64'd1 << FRAC_BITS);
  localparam logic [M-1:0] TB_RESET = M'(64'd3 << (FRAC_BITS - 1));

  localparam logic [2:0] REG_RATED_VELOCITY = 3'd0;
  localparam logic [2:0] REG_RATED_CURRENT  = 3'd1;
  localparam logic [2:0] REG_RATED_TORQUE   = 3'd2;
  localparam logic [2:0] REG_VELOCITY_BOOST = 3'd3;
  localparam logic [2:0] REG_TORQUE_BOOST   = 3'd4;

  logic [M-1:0] rated_velocity;
  logic [M-1:0] rated_current;
  logic [M-1:0] rated_torque;
  logic [M-1:0] velocity_boost;
  logic [M-1:0] torque_boost;

  always_ff @(posedge clk) begin
    if (rst) begin
      rated_velocity <= RV_RESET;
      rated_current  <= RC_RESET;
      rated_torque   <= RT_RESET;
      velocity_boost <= VB_RESET;
      torque_boost   <= TB_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RATED_VELOCITY: rated_velocity <= cfg_data;
        REG_RATED_CURRENT:  rated_current  <= cfg_data;
        REG_RATED_TORQUE:   rated_torque   <= cfg_data;
        REG_VELOCITY_BOOST: velocity_boost <= cfg_data;
        REG_TORQUE_BOOST:   torque_boost   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  // stage 0: magnitude, floor, nominal current and ratio numerator
  logic         neg;
  logic [W-1:0] mag;
  logic [IW-1:0] idn_prod;

  assign neg      = velocity[W-1];
  assign mag      = neg ? (~unsigned'(velocity) + W'(1)) : unsigned'(velocity);
  assign idn_prod = IW'(rated_current) * IW'(fwcl_pkg::INV_SQRT2_Q32) + IW'(64'h8000_0000);

  logic          s0_valid;
  logic [W-1:0]  s0_a;
  logic          s0_pos;
  logic [M-1:0]  s0_idn;
  logic [PW-1:0] s0_nr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_a   <= (mag < FLOOR_01) ? FLOOR_01 : mag;
      s0_pos <= !neg && (velocity != '0);
      s0_idn <= idn_prod[IW-2:32];
      s0_nr  <= PW'(rated_velocity) * PW'(velocity_boost);
    end
  end

  // speed ratio
  logic         a_valid;
  logic [M-1:0] a_r;
  logic [W-1:0] a_tag;

  fwcl_div #(.WORD_BITS(W), .TAG_BITS(W)) u_div_ratio (
    .clk(clk), .rst(rst),
    .ctl('{advance: en, valid: s0_valid}),
    .num(s0_nr), .den(s0_a), .tag({s0_pos, s0_idn}),
    .out_valid(a_valid), .quo(a_r), .tag_out(a_tag)
  );

  // boosted and ratio-capped q limits
  logic         qb_valid, qr_valid;
  logic [M-1:0] qb, qr;
  logic         qb_pos;
  logic [M-1:0] qr_idn;

  fwcl_mulsat #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS), .TAG_BITS(1)) u_mul_qb (
    .clk(clk), .rst(rst),
    .ctl('{advance: en, valid: a_valid}),
    .op_a(a_tag[M-1:0]), .op_b(torque_boost), .tag(a_tag[M]),
    .out_valid(qb_valid), .prod(qb), .tag_out(qb_pos)
  );

  fwcl_mulsat #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS), .TAG_BITS(M)) u_mul_qr (
    .clk(clk), .rst(rst),
    .ctl('{advance: en, valid: a_valid}),
    .op_a(a_tag[M-1:0]), .op_b(a_r), .tag(a_tag[M-1:0]),
    .out_valid(qr_valid), .prod(qr), .tag_out(qr_idn)
  );

  // stage 2: select d and the q limits by direction
  logic [M-1:0] cap;
  assign cap = (qb < qr) ? qb : qr;

  logic          s2_valid;
  logic [M-1:0]  s2_d, s2_qmax, s2_qmin, s2_idn;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= qb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_d    <= (qr_idn < qr) ? qr_idn : qr;
      s2_qmax <= qb_pos ? cap : qb;
      s2_qmin <= qb_pos ? qb : cap;
      s2_idn  <= qr_idn;
    end
  end

  // d over nominal current as a fraction
  logic             b_valid;
  logic [M-1:0]     b_u;
  logic [4*M-1:0]   b_tag;

  fwcl_div #(.WORD_BITS(W), .TAG_BITS(4 * M)) u_div_frac (
    .clk(clk), .rst(rst),
    .ctl('{advance: en, valid: s2_valid}),
    .num(PW'(s2_d) << FRAC_BITS), .den({1'b0, s2_idn}),
    .tag({s2_qmax, s2_qmin, s2_d, s2_idn}),
    .out_valid(b_valid), .quo(b_u), .tag_out(b_tag)
  );

  logic           m1_valid, m2_valid;
  logic [M-1:0]   m1, m2;
  logic [3*M-1:0] m1_tag;
  logic [M-1:0]   m2_idn;

  fwcl_mulsat #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS), .TAG_BITS(3 * M)) u_mul_m1 (
    .clk(clk), .rst(rst),
    .ctl('{advance: en, valid: b_valid}),
    .op_a(b_tag[4*M-1:3*M]), .op_b(b_u), .tag(b_tag[4*M-1:M]),
    .out_valid(m1_valid), .prod(m1), .tag_out(m1_tag)
  );

  fwcl_mulsat #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS), .TAG_BITS(M)) u_mul_m2 (
    .clk(clk), .rst(rst),
    .ctl('{advance: en, valid: b_valid}),
    .op_a(b_tag[3*M-1:2*M]), .op_b(b_u), .tag(b_tag[M-1:0]),
    .out_valid(m2_valid), .prod(m2), .tag_out(m2_idn)
  );

  // stage 4: scale by the floored rated torque
  logic [M-1:0] tn;
  assign tn = (rated_torque < FLOOR_01[M-1:0]) ? FLOOR_01[M-1:0] : rated_torque;

  logic           s4_valid;
  logic [PW-1:0]  s4_n1, s4_n2;
  logic [3*M-1:0] s4_tag;
  logic [M-1:0]   s4_idn;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_n1  <= PW'(m1) * PW'(tn);
      s4_n2  <= PW'(m2) * PW'(tn);
      s4_tag <= m1_tag;
      s4_idn <= m2_idn;
    end
  end

  logic           c1_valid, c2_valid;
  logic [M-1:0]   t1, t2;
  logic [3*M-1:0] c1_tag;
  logic           c2_zero;

  fwcl_div #(.WORD_BITS(W), .TAG_BITS(3 * M)) u_div_tmax (
    .clk(clk), .rst(rst),
    .ctl('{advance: en, valid: s4_valid}),
    .num(s4_n1), .den({1'b0, s4_idn}), .tag(s4_tag),
    .out_valid(c1_valid), .quo(t1), .tag_out(c1_tag)
  );

  fwcl_div #(.WORD_BITS(W), .TAG_BITS(1)) u_div_tmin (
    .clk(clk), .rst(rst),
    .ctl('{advance: en, valid: s4_valid}),
    .num(s4_n2), .den({1'b0, s4_idn}), .tag(s4_idn == '0),
    .out_valid(c2_valid), .quo(t2), .tag_out(c2_zero)
  );

  // output register, signs applied last; zero nominal current gives zero torque
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_current_max <= $signed({1'b0, c1_tag[3*M-1:2*M]});
      q_current_min <= $signed(~{1'b0, c1_tag[2*M-1:M]} + W'(1));
      d_current     <= $signed({1'b0, c1_tag[M-1:0]});
      torque_max    <= c2_zero ? '0 : $signed({1'b0, t1});
      torque_min    <= c2_zero ? '0 : $signed(~{1'b0, t2} + W'(1));
    end
  end

  `FWCL_IMPLIES(a_q_lanes_aligned, 1'b1, qb_valid == qr_valid)
  `FWCL_IMPLIES(a_m_lanes_aligned, 1'b1, m1_valid == m2_valid)
  `FWCL_IMPLIES(a_t_lanes_aligned, 1'b1, c1_valid == c2_valid)
  `FWCL_NEXT(a_held_result_stays, out_valid && out_stall, out_valid)
  `FWCL_IMPLIES(a_d_nonnegative, out_valid, !d_current[W-1])

endmodule

`default_nettype wire

// File: verif/field_weakening_current_limits_checker.sv
// checker for the field weakening limit block: predicts each item's limits and compares
`default_nettype none

module field_weakening_current_limits_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [30:0]        cfg_data,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic signed [31:0] velocity,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic signed [31:0] d_current,
  input  wire logic signed [31:0] q_current_max,
  input  wire logic signed [31:0] q_current_min,
  input  wire logic signed [31:0] torque_max,
  input  wire logic signed [31:0] torque_min,
  output int                      fail_count,
  output int                      pending_count,
  output int                      result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REG_RATED_VELOCITY = 0;
  localparam int REG_RATED_CURRENT = 1;
  localparam int REG_RATED_TORQUE = 2;
  localparam int REG_VELOCITY_BOOST = 3;
  localparam int REG_TORQUE_BOOST = 4;
  localparam logic [63:0] MAXV = 64'h7fff_ffff;
  localparam logic [63:0] FLOOR_01 = 64'd655;

  typedef struct packed {
    logic [31:0] d;
    logic [31:0] qmax;
    logic [31:0] qmin;
    logic [31:0] tmax;
    logic [31:0] tmin;
  } limits_t;

  logic [30:0] rated_vel, rated_cur, rated_trq, spd_boost, trq_boost;
  limits_t expected_limits[$];

  function automatic logic [63:0] sat(logic [127:0] x);
    return (x > {64'd0, MAXV}) ? MAXV : x[63:0];
  endfunction

  function automatic logic [63:0] torque_mag(logic [63:0] iq, logic [63:0] u,
                                             logic [63:0] tn, logic [63:0] idn);
    logic [63:0] m;
    if (idn == 0) return 0;
    m = sat((128'(iq) * 128'(u)) >> 16);
    return sat((128'(m) * 128'(tn)) / 128'(idn));
  endfunction

  function automatic limits_t predict_limits(logic [31:0] raw);
    limits_t res;
    logic neg, pos;
    logic [63:0] mag, a, tn, idn, r, qb, qr, d, cap, qmax, qmin, u;
    logic [63:0] tmax_mag, tmin_mag;
    neg = raw[31];
    mag = neg ? 64'(33'h1_0000_0000 - 33'(raw)) : 64'(raw);
    pos = !neg && raw != 0;
    a = (mag > FLOOR_01) ? mag : FLOOR_01;
    tn = (64'(rated_trq) > FLOOR_01) ? 64'(rated_trq) : FLOOR_01;
    idn = sat((128'(rated_cur) * 128'd3037000500 + (128'd1 << 31)) >> 32);
    r = sat((128'(rated_vel) * 128'(spd_boost)) / 128'(a));
    qb = sat((128'(idn) * 128'(trq_boost)) >> 16);
    qr = sat((128'(idn) * 128'(r)) >> 16);
    d = (idn < qr) ? idn : qr;
    cap = (qb < qr) ? qb : qr;
    if (pos) begin
      qmax = cap; qmin = qb;
    end else begin
      qmax = qb; qmin = cap;
    end
    u = (idn == 0) ? 0 : sat((128'(d) << 16) / 128'(idn));
    tmax_mag = torque_mag(qmax, u, tn, idn);
    tmin_mag = torque_mag(qmin, u, tn, idn);
    res.d = d[31:0];
    res.qmax = qmax[31:0];
    res.qmin = -qmin[31:0];
    res.tmax = tmax_mag[31:0];
    res.tmin = -tmin_mag[31:0];
    return res;
  endfunction

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d actual %0d", name, $signed(exp_v), $signed(act_v));
      fail_count++;
    end
  endtask

  assign pending_count = expected_limits.size();

  always @(posedge clk) begin
    limits_t e;
    if (rst) begin
      rated_vel <= 31'd10294371;
      rated_cur <= 31'd983040;
      rated_trq <= 31'd1507328;
      spd_boost <= 31'd65536;
      trq_boost <= 31'd98304;
      expected_limits.delete();
      fail_count = 0;
      result_count <= 0;
    end else begin
      if (in_valid && !in_stall) expected_limits.push_back(predict_limits(velocity));
      if (out_valid && !out_stall) begin
        result_count <= result_count + 1;
        if (expected_limits.size() == 0) begin
          $error("result with no item waiting");
          fail_count++;
        end else begin
          e = expected_limits.pop_front();
          compare_field("d_current", e.d, d_current);
          compare_field("q_current_max", e.qmax, q_current_max);
          compare_field("q_current_min", e.qmin, q_current_min);
          compare_field("torque_max", e.tmax, torque_max);
          compare_field("torque_min", e.tmin, torque_min);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_RATED_VELOCITY: rated_vel <= cfg_data;
          REG_RATED_CURRENT: rated_cur <= cfg_data;
          REG_RATED_TORQUE: rated_trq <= cfg_data;
          REG_VELOCITY_BOOST: spd_boost <= cfg_data;
          REG_TORQUE_BOOST: trq_boost <= cfg_data;
          default: ;
        endcase
      end
    end
  end
endmodule

`default_nettype wire

// File: verif/field_weakening_current_limits_tb.sv
// testbench top: stimulus, configuration phases and verdict for the field weakening block
`default_nettype none

module field_weakening_current_limits_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_RATED_VELOCITY = 3'd0;
  localparam logic [2:0] REG_RATED_CURRENT = 3'd1;
  localparam logic [2:0] REG_RATED_TORQUE = 3'd2;
  localparam logic [2:0] REG_VELOCITY_BOOST = 3'd3;
  localparam logic [2:0] REG_TORQUE_BOOST = 3'd4;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int LATENCY = 102;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;
  logic in_valid = 0, out_stall = 0;
  logic signed [31:0] velocity = '0;
  logic in_stall, out_valid;
  logic signed [31:0] d_current, q_current_max, q_current_min, torque_max, torque_min;
  int fail_count, pending_count, result_count;
  int cycle_count = 0;
  bit calm = 0;
  int sent = 0;

  field_weakening_current_limits uut (.*);
  field_weakening_current_limits_checker chk (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver stalls in short bursts until the calm tail of the run
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 3);
        out_stall <= 1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_velocity(logic [31:0] v);
    int n;
    // a preceding register write ends here
    cfg_we <= 0;
    if (!calm && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 3);
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    velocity <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // leaves the write enable high so writes can follow back to back
  task automatic write_reg(logic [2:0] idx, logic [30:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  function automatic logic [31:0] random_velocity();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 2000) - 1000;
      2: return $urandom_range(0, 1 << 24) - (1 << 23);
      3: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
      default: return $urandom_range(0, 1 << 26) - (1 << 25);
    endcase
  endfunction

  task automatic random_regs();
    logic [30:0] v[5];
    for (int i = 0; i < 5; i++)
      case ($urandom_range(0, 5))
        0: v[i] = '0;
        1: v[i] = '1;
        2: v[i] = 31'($urandom);
        default: v[i] = 31'($urandom_range(0, 1 << 23));
      endcase
    write_reg(REG_RATED_VELOCITY, v[0]);
    write_reg(REG_RATED_CURRENT, v[1]);
    write_reg(REG_RATED_TORQUE, v[2]);
    write_reg(REG_VELOCITY_BOOST, v[3]);
    write_reg(REG_TORQUE_BOOST, v[4]);
  endtask

  initial begin
    logic [31:0] directed[$] = '{32'h0, 32'h1, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                                 32'd655, -32'sd655, 32'd654, 32'd656, 32'h0001_0000,
                                 -32'sd65536, 32'h009d_1463, -32'sd10294371, 32'h00a0_0000,
                                 32'h5555_5555, 32'haaaa_aaaa};
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (directed[i]) send_velocity(directed[i]);
    drain();
    // extremes of every register, then zero current and floored torque
    foreach (directed[i]) begin
      if (i == 0) begin
        write_reg(REG_RATED_VELOCITY, '1);
        write_reg(REG_VELOCITY_BOOST, '1);
        write_reg(REG_RATED_CURRENT, '1);
        write_reg(REG_TORQUE_BOOST, '1);
        write_reg(REG_RATED_TORQUE, '1);
      end
      send_velocity(directed[i]);
    end
    drain();
    write_reg(REG_RATED_CURRENT, '0);
    write_reg(REG_RATED_TORQUE, '0);
    write_reg(REG_UNUSED, 31'd12345);
    foreach (directed[i]) send_velocity(directed[i]);
    drain();
    for (int phase = 0; phase < 9; phase++) begin
      if (phase == 8) begin
        write_reg(REG_RATED_VELOCITY, 31'd10294371);
        write_reg(REG_RATED_CURRENT, 31'd983040);
        write_reg(REG_RATED_TORQUE, 31'd1507328);
        write_reg(REG_VELOCITY_BOOST, 31'd65536);
        write_reg(REG_TORQUE_BOOST, 31'd98304);
        calm = 1;
      end else if (phase > 0) begin
        random_regs();
      end
      repeat (200) send_velocity(random_velocity());
      drain();
    end
    repeat (LATENCY) @(posedge clk);
    $display("%0d velocity items sent, %0d limit sets checked over several register settings",
             sent, result_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/fwcl_pkg.sv
rtl/fwcl_mulsat.sv
rtl/fwcl_div.sv
rtl/field_weakening_current_limits.sv
verif/field_weakening_current_limits_checker.sv
verif/field_weakening_current_limits_tb.sv
